>>> src/polar_gaussian_sampler_defines.svh
// Assertion macros for the checker of the polar Gaussian sampler.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef POLAR_GAUSSIAN_SAMPLER_DEFINES_SVH
`define POLAR_GAUSSIAN_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PGS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pgs_pkg.sv
// Package for the polar Gaussian sampler: beat types, widths and constants.
// No dependencies.
package pgs_pkg;

    localparam int U_BITS        = 24;   // uniform fraction bits
    localparam int FRAC_BITS     = 16;   // sample fraction bits
    localparam int SAMPLE_BITS   = 20;
    localparam int M_BITS        = 2 * U_BITS;
    localparam int LOG_STEPS     = 24;   // fraction bits of -log2(m)
    localparam int T_BITS        = 31;   // Q.30 mantissa
    localparam int NL2_BITS      = 30;
    localparam int V_BITS        = 31;
    localparam int S_ROOT_BITS   = 32;   // root of M * 4^k
    localparam int G_ROOT_BITS   = 31;   // root of V * 2^24
    localparam int Q_BITS        = 31;   // unit ratio, Q.30
    localparam int R_BITS        = 63;   // divider remainder
    localparam int P_BITS        = 62;
    localparam int RND_SHIFT     = 54 - FRAC_BITS;

    // 2 ln 2 in Q.32 is 2^32 plus this low part
    localparam logic [30:0] TWO_LN2_LO = 31'd1659121648;

    localparam logic [23:0] SAMPLE_MAX_MAG = 24'd524287;
    localparam logic [23:0] SAMPLE_MIN_MAG = 24'd524288;

    typedef struct packed {
        logic [U_BITS-1:0] first_uniform;
        logic [U_BITS-1:0] second_uniform;
    } uniform_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] normal_sample;
        logic                          last_of_pair;
    } sample_t;

endpackage

>>> src/pgs_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on nothing; the top level steps it with its pipeline enable.
module pgs_sqrt_pipe #(
    parameter int ROOT_BITS = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [2*ROOT_BITS-1:0]   operand,
    output logic [ROOT_BITS-1:0]     root
);

    logic [2*ROOT_BITS-1:0] op_reg   [ROOT_BITS];
    logic [ROOT_BITS+1:0]   rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0]   root_reg [ROOT_BITS];

    for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
        logic [2*ROOT_BITS-1:0] op_in;
        logic [ROOT_BITS+1:0]   rem_in;
        logic [ROOT_BITS-1:0]   root_in;
        logic [ROOT_BITS+1:0]   rem_sh;
        logic [ROOT_BITS+1:0]   trial;
        logic [2*ROOT_BITS-1:0] op_next;
        logic [ROOT_BITS+1:0]   rem_next;
        logic [ROOT_BITS-1:0]   root_next;

        if (i == 0) begin : g_first
            assign op_in   = operand;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign op_in   = op_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        always_comb
        begin
            rem_sh  = {rem_in[ROOT_BITS-1:0], op_in[2*ROOT_BITS-1 -: 2]};
            trial   = {root_in, 2'b01};
            op_next = {op_in[2*ROOT_BITS-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[i]   <= op_next;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_BITS-1];

endmodule

>>> src/polar_gaussian_sampler.sv
// Marsaglia polar Gaussian sampler: each accepted uniform beat runs through the pipeline to
// its first sample beat; the second follows in the next cycle if the sink is ready.
// Throughput: one uniform beat per cycle when not stalled, into a 73-stage pipeline that
// stalls as a whole; each kept pair leaves as two sample beats. Rejected pairs leave no beat.
// Reset: rst_n clears all valid bits and the output buffer; the data path has no reset.
module polar_gaussian_sampler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              uniform_valid,
    output logic              uniform_ready,
    input  pgs_pkg::uniform_t uniform,
    output logic              sample_valid,
    input  logic              sample_ready,
    output pgs_pkg::sample_t  sample
);

    import pgs_pkg::*;

    // Log stages run alongside the root of M * 4^k; divider stages alongside
    // the root of V * 2^24.
    localparam int LSTG = S_ROOT_BITS;
    localparam int DSTG = G_ROOT_BITS;

    typedef struct packed {
        logic              xneg;
        logic              yneg;
        logic [U_BITS-1:0] xm;
        logic [U_BITS-1:0] ym;
        logic [4:0]        k;
    } side_t;

    typedef enum logic [1:0] {
        OB_EMPTY,
        OB_LAST,
        OB_BOTH
    } ob_state_t;

    logic en;
    logic load_ok;

    // ---------------- stage 0: map u to 2u-1 as sign and magnitude
    logic [U_BITS:0] x2_c, y2_c, xmag_c, ymag_c;
    logic            v0_reg, rej0_reg;
    side_t           side0_reg;

    always_comb
    begin
        x2_c = {uniform.first_uniform, 1'b0};
        y2_c = {uniform.second_uniform, 1'b0};
        xmag_c = x2_c[U_BITS] ? {1'b0, x2_c[U_BITS-1:0]} : ({1'b1, {U_BITS{1'b0}}} - x2_c);
        ymag_c = y2_c[U_BITS] ? {1'b0, y2_c[U_BITS-1:0]} : ({1'b1, {U_BITS{1'b0}}} - y2_c);
    end

    // ---------------- stage 1: squares
    logic                v1_reg;
    side_t               side1_reg;
    logic [M_BITS-1:0]   xx1_reg, yy1_reg;

    // ---------------- stage 2: sum and rejection
    logic [M_BITS:0]     msum_c;
    logic                v2_reg;
    side_t               side2_reg;
    logic [M_BITS-1:0]   m2_reg;

    assign msum_c = {1'b0, xx1_reg} + {1'b0, yy1_reg};

    // ---------------- stage 3: bit length of M
    logic [5:0]          blen_c;
    logic                v3_reg;
    side_t               side3_reg;
    logic [M_BITS-1:0]   m3_reg;
    logic [5:0]          b3_reg;

    always_comb
    begin
        blen_c = '0;
        for (int i = 0; i < M_BITS; i++)
        begin
            if (m2_reg[i])
            begin
                blen_c = 6'(i + 1);
            end
        end
    end

    // ---------------- stage 4 (log index 0): normalize, shift for the root
    logic [5:0]          e4_c;
    logic [6:0]          kk_c;
    logic [4:0]          k4_c;
    logic [M_BITS-1:0]   t4_wide_c;
    logic [63:0]         sop_c;
    side_t               side4_c;

    always_comb
    begin
        e4_c = b3_reg - 6'd1;
        kk_c = 7'd64 - {1'b0, b3_reg};
        k4_c = kk_c[5:1];
        if (e4_c >= 6'd30)
        begin
            t4_wide_c = m3_reg >> (e4_c - 6'd30);
        end
        else
        begin
            t4_wide_c = m3_reg << (6'd30 - e4_c);
        end
        sop_c     = {{(64 - M_BITS){1'b0}}, m3_reg} << {k4_c, 1'b0};
        side4_c   = side3_reg;
        side4_c.k = k4_c;
    end

    // Log pipeline: index 0 is stage 4, indexes 1..LOG_STEPS square one bit each, the rest up to LSTG pass through.
    logic [LSTG:0]          lv_reg;
    side_t                  lside_reg [LSTG+1];
    logic [5:0]             le_reg    [LSTG+1];
    logic [T_BITS-1:0]      lt_reg    [LSTG+1];
    logic [LOG_STEPS-1:0]   lf_reg    [LSTG+1];
    logic [63:0]            sop_reg;
    logic [S_ROOT_BITS-1:0] s_root;

    for (genvar j = 1; j <= LSTG; j++) begin : g_log
        logic [2*T_BITS-1:0]  sq;
        logic [T_BITS:0]      t2;
        logic [T_BITS-1:0]    t_next;
        logic [LOG_STEPS-1:0] f_next;

        always_comb
        begin
            sq = lt_reg[j-1] * lt_reg[j-1];
            t2 = sq[2*T_BITS-1:T_BITS-1];
            if (j > LOG_STEPS)
            begin
                t_next = lt_reg[j-1];
                f_next = lf_reg[j-1];
            end
            else if (t2[T_BITS])
            begin
                t_next = t2[T_BITS:1];
                f_next = {lf_reg[j-1][LOG_STEPS-2:0], 1'b1};
            end
            else
            begin
                t_next = t2[T_BITS-1:0];
                f_next = {lf_reg[j-1][LOG_STEPS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lside_reg[j] <= lside_reg[j-1];
                le_reg[j]    <= le_reg[j-1];
                lt_reg[j]    <= t_next;
                lf_reg[j]    <= f_next;
            end
        end
    end

    pgs_sqrt_pipe #(
        .ROOT_BITS (S_ROOT_BITS)
    ) u_sqrt_norm (
        .clk     (clk),
        .en      (en),
        .operand (sop_reg),
        .root    (s_root)
    );

    // ---------------- stage 5: -log2(m) in Q.24
    logic                   v5_reg;
    side_t                  side5_reg;
    logic [S_ROOT_BITS-1:0] s5_reg;
    logic [NL2_BITS-1:0]    nl2_5_reg;
    logic [NL2_BITS-1:0]    nl2_c;
    logic [6:0]             ex_c;

    always_comb
    begin
        ex_c  = 7'(M_BITS) - {1'b0, le_reg[LSTG]};
        nl2_c = {ex_c[5:0], {LOG_STEPS{1'b0}}} - {6'b0, lf_reg[LSTG]};
    end

    // ---------------- stage 6: low part of the 2 ln 2 product
    logic                   v6_reg;
    side_t                  side6_reg;
    logic [S_ROOT_BITS-1:0] s6_reg;
    logic [NL2_BITS-1:0]    nl2_6_reg;
    logic [60:0]            prod6_reg;

    // ---------------- stage 7 (divider index 0): V, dividends
    logic [V_BITS-1:0]      v7_c;
    logic [2*G_ROOT_BITS-1:0] gop_c;
    logic [5:0]             dsh_c;
    logic [R_BITS-1:0]      dx_c, dy_c;
    logic [2*G_ROOT_BITS-1:0] gop_reg;

    always_comb
    begin
        v7_c  = {1'b0, nl2_6_reg} + {2'b0, prod6_reg[60:32]};
        gop_c = {{(2*G_ROOT_BITS - V_BITS - 24){1'b0}}, v7_c, 24'b0};
        dsh_c = {1'b0, side6_reg.k} + 6'd30;
        dx_c  = {{(R_BITS - U_BITS){1'b0}}, side6_reg.xm} << dsh_c;
        dy_c  = {{(R_BITS - U_BITS){1'b0}}, side6_reg.ym} << dsh_c;
    end

    // Divider pipeline: one quotient bit per stage for both magnitudes.
    logic [DSTG:0]          dv_reg;
    logic                   dxn_reg [DSTG+1];
    logic                   dyn_reg [DSTG+1];
    logic [S_ROOT_BITS-1:0] ds_reg  [DSTG+1];
    logic [R_BITS-1:0]      rx_reg  [DSTG+1];
    logic [R_BITS-1:0]      ry_reg  [DSTG+1];
    logic [Q_BITS-1:0]      qx_reg  [DSTG+1];
    logic [Q_BITS-1:0]      qy_reg  [DSTG+1];
    logic [G_ROOT_BITS-1:0] g_root;

    for (genvar j = 1; j <= DSTG; j++) begin : g_div
        localparam int QB = DSTG - j;
        logic [R_BITS-1:0] trial;
        logic [R_BITS-1:0] rx_next, ry_next;
        logic              bx, by;

        always_comb
        begin
            trial = {{(R_BITS - S_ROOT_BITS){1'b0}}, ds_reg[j-1]} << QB;
            bx    = (rx_reg[j-1] >= trial);
            by    = (ry_reg[j-1] >= trial);
            rx_next = bx ? (rx_reg[j-1] - trial) : rx_reg[j-1];
            ry_next = by ? (ry_reg[j-1] - trial) : ry_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dxn_reg[j] <= dxn_reg[j-1];
                dyn_reg[j] <= dyn_reg[j-1];
                ds_reg[j]  <= ds_reg[j-1];
                rx_reg[j]  <= rx_next;
                ry_reg[j]  <= ry_next;
                qx_reg[j]  <= {qx_reg[j-1][Q_BITS-2:0], bx};
                qy_reg[j]  <= {qy_reg[j-1][Q_BITS-2:0], by};
            end
        end
    end

    pgs_sqrt_pipe #(
        .ROOT_BITS (G_ROOT_BITS)
    ) u_sqrt_log (
        .clk     (clk),
        .en      (en),
        .operand (gop_reg),
        .root    (g_root)
    );

    // ---------------- stage 8: ratio times sqrt(-2 ln m)
    logic               v8_reg;
    logic               xn8_reg, yn8_reg;
    logic [P_BITS-1:0]  px8_reg, py8_reg;

    // ---------------- stage 9: round half up, sign, saturate
    logic                          v9_reg;
    logic signed [SAMPLE_BITS-1:0] sy9_reg, sx9_reg;

    function automatic logic [SAMPLE_BITS-1:0] round_sat(
        input logic [P_BITS-1:0] p,
        input logic              neg
    );
        logic [P_BITS-1:0] sum;
        logic [23:0]       q;
        sum = p + (P_BITS'(1) << (RND_SHIFT - 1));
        q   = sum[RND_SHIFT +: 24];
        if (neg)
        begin
            if (q > SAMPLE_MIN_MAG)
            begin
                q = SAMPLE_MIN_MAG;
            end
            round_sat = SAMPLE_BITS'(24'd0 - q);
        end
        else
        begin
            if (q > SAMPLE_MAX_MAG)
            begin
                q = SAMPLE_MAX_MAG;
            end
            round_sat = q[SAMPLE_BITS-1:0];
        end
    endfunction

    // ---------------- output buffer: holds one pair, shows y then x
    ob_state_t                     ob_state_reg;
    logic signed [SAMPLE_BITS-1:0] hold_y_reg, hold_x_reg;
    logic                          load;

    assign load_ok = (ob_state_reg == OB_EMPTY) || ((ob_state_reg == OB_LAST) && sample_ready);
    assign load    = v9_reg && load_ok;
    // Advance the whole pipeline unless a finished pair is blocked.
    assign en            = !v9_reg || load_ok;
    assign uniform_ready = en;

    assign sample_valid        = (ob_state_reg != OB_EMPTY);
    assign sample.normal_sample = (ob_state_reg == OB_BOTH) ? hold_y_reg : hold_x_reg;
    assign sample.last_of_pair  = (ob_state_reg == OB_LAST);

    // Valid bits: drop rejected pairs at stages 1 and 2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            lv_reg <= '0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            dv_reg <= '0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= uniform_valid;
            v1_reg <= v0_reg && !rej0_reg;
            v2_reg <= v1_reg && (msum_c != '0) && !msum_c[M_BITS];
            v3_reg <= v2_reg;
            lv_reg <= {lv_reg[LSTG-1:0], v3_reg};
            v5_reg <= lv_reg[LSTG];
            v6_reg <= v5_reg;
            dv_reg <= {dv_reg[DSTG-1:0], v6_reg};
            v8_reg <= dv_reg[DSTG];
            v9_reg <= v8_reg;
        end
    end

    // Data path: hold on stall, no reset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rej0_reg       <= xmag_c[U_BITS] || ymag_c[U_BITS];
            side0_reg.xneg <= !x2_c[U_BITS];
            side0_reg.yneg <= !y2_c[U_BITS];
            side0_reg.xm   <= xmag_c[U_BITS-1:0];
            side0_reg.ym   <= ymag_c[U_BITS-1:0];
            side0_reg.k    <= '0;

            side1_reg <= side0_reg;
            xx1_reg   <= side0_reg.xm * side0_reg.xm;
            yy1_reg   <= side0_reg.ym * side0_reg.ym;

            side2_reg <= side1_reg;
            m2_reg    <= msum_c[M_BITS-1:0];

            side3_reg <= side2_reg;
            m3_reg    <= m2_reg;
            b3_reg    <= blen_c;

            lside_reg[0] <= side4_c;
            le_reg[0]    <= e4_c;
            lt_reg[0]    <= t4_wide_c[T_BITS-1:0];
            lf_reg[0]    <= '0;
            sop_reg      <= sop_c;

            side5_reg <= lside_reg[LSTG];
            s5_reg    <= s_root;
            nl2_5_reg <= nl2_c;

            side6_reg <= side5_reg;
            s6_reg    <= s5_reg;
            nl2_6_reg <= nl2_5_reg;
            prod6_reg <= nl2_5_reg * TWO_LN2_LO;

            dxn_reg[0] <= side6_reg.xneg;
            dyn_reg[0] <= side6_reg.yneg;
            ds_reg[0]  <= s6_reg;
            rx_reg[0]  <= dx_c;
            ry_reg[0]  <= dy_c;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            gop_reg    <= gop_c;

            xn8_reg <= dxn_reg[DSTG];
            yn8_reg <= dyn_reg[DSTG];
            px8_reg <= qx_reg[DSTG] * g_root;
            py8_reg <= qy_reg[DSTG] * g_root;

            sy9_reg <= round_sat(py8_reg, yn8_reg);
            sx9_reg <= round_sat(px8_reg, xn8_reg);
        end
    end

    // Output buffer: load a pair, then drain y and x beats.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_state_reg <= OB_EMPTY;
        end
        else
        begin
            unique case (ob_state_reg)
                OB_EMPTY:
                begin
                    if (load)
                    begin
                        ob_state_reg <= OB_BOTH;
                    end
                end
                OB_BOTH:
                begin
                    if (sample_ready)
                    begin
                        ob_state_reg <= OB_LAST;
                    end
                end
                OB_LAST:
                begin
                    if (load)
                    begin
                        ob_state_reg <= OB_BOTH;
                    end
                    else if (sample_ready)
                    begin
                        ob_state_reg <= OB_EMPTY;
                    end
                end
                default:
                begin
                    ob_state_reg <= OB_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_y_reg <= sy9_reg;
            hold_x_reg <= sx9_reg;
        end
    end

endmodule

>>> src/pgs_checker.sv
// Port-level checker for the polar Gaussian sampler, bound to the top level.
// Depends on pgs_pkg and polar_gaussian_sampler_defines.svh.
`include "polar_gaussian_sampler_defines.svh"

module pgs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              uniform_valid,
    input logic              uniform_ready,
    input pgs_pkg::uniform_t uniform,
    input logic              sample_valid,
    input logic              sample_ready,
    input pgs_pkg::sample_t  sample
);

    import pgs_pkg::*;

    // Hold a stalled beat.
    `PGS_ASSERT_NEXT(a_hold_stalled, sample_valid && !sample_ready, sample_valid && $stable(sample), "stalled sample beat changed")
    // The first beat of a pair is always followed by its last beat.
    `PGS_ASSERT_NEXT(a_pair_second, sample_valid && sample_ready && !sample.last_of_pair, sample_valid && sample.last_of_pair, "pair not completed")
    // An empty output side never blocks the input.
    `PGS_ASSERT_SAME(a_ready_when_empty, !sample_valid, uniform_ready, "input stalled with empty output")
    // Nothing pending right after reset.
    `PGS_ASSERT_SAME(a_clean_start, $rose(rst_n), !sample_valid, "sample beat right after reset")

endmodule

bind polar_gaussian_sampler pgs_checker u_pgs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .uniform_valid (uniform_valid),
    .uniform_ready (uniform_ready),
    .uniform       (uniform),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample)
);
